### hw/rtl/correlated_hunt_bisection_locator_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef CORRELATED_HUNT_BISECTION_LOCATOR_MACROS_SVH
`define CORRELATED_HUNT_BISECTION_LOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHBL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/chbl_pkg.sv
`timescale 1ns / 1ps

package chbl_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = IDX_W + 1;
  localparam int VAL_W       = 32;
  localparam int THR_W       = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_THRESH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCENDING    = 2'd3;

  // Register values after reset.
  localparam logic [LEN_W-1:0] RST_TABLE_LENGTH = '0;
  localparam logic [LEN_W-1:0] RST_RANGE_SIZE   = LEN_W'(2);
  localparam logic [THR_W-1:0] RST_CORR_THRESH  = THR_W'(1);
  localparam logic             RST_ASCENDING    = 1'b1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } chbl_op_e;

  // Table write port.
  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        addr;
    logic signed [VAL_W-1:0] data;
  } chbl_wr_t;

  // Configuration seen by the search sequencer.
  typedef struct packed {
    logic [LEN_W-1:0] table_length;
    logic [LEN_W-1:0] range_size;
    logic [THR_W-1:0] corr_thresh;
    logic             ascending;
  } chbl_cfg_t;

  // One result beat.
  typedef struct packed {
    logic [IDX_W-1:0] range_start;
    logic             error;
    logic             correlated;
  } chbl_res_t;

  // True when the key lies at or past a table value for an ascending table, or strictly past it for a descending one.
  function automatic logic at_or_past(logic signed [VAL_W-1:0] key,
                                      logic signed [VAL_W-1:0] val,
                                      logic                    asc);
    logic ge;
    ge = (key >= val);
    return (ge == asc);
  endfunction

endpackage

### hw/rtl/chbl_if.sv
`timescale 1ns / 1ps

// Input channel: table writes and search keys.
interface chbl_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      opcode;
  logic [chbl_pkg::IDX_W-1:0]                entry_index;
  logic signed [chbl_pkg::VAL_W-1:0]         entry_value;
  logic signed [chbl_pkg::VAL_W-1:0]         key;

  modport source (output valid, opcode, entry_index, entry_value, key, input ready);
  modport sink   (input valid, opcode, entry_index, entry_value, key, output ready);
endinterface

// Output channel: one beat per search.
interface chbl_out_if;
  logic                       valid;
  logic                       ready;
  logic [chbl_pkg::IDX_W-1:0] range_start;
  logic                       error;
  logic                       correlated;

  modport source (output valid, range_start, error, correlated, input ready);
  modport sink   (input valid, range_start, error, correlated, output ready);
endinterface

### hw/rtl/chbl_ram.sv
`timescale 1ns / 1ps

// Value table: one write port, one read port with registered read data.
module chbl_ram (
  input  logic                              clk_i,
  input  chbl_pkg::chbl_wr_t                wr_i,
  input  logic [chbl_pkg::IDX_W-1:0]        rd_addr_i,
  output logic signed [chbl_pkg::VAL_W-1:0] rd_data_o
);

  logic signed [chbl_pkg::VAL_W-1:0] mem [chbl_pkg::TABLE_DEPTH];
  logic signed [chbl_pkg::VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/chbl_seq.sv
`timescale 1ns / 1ps

// Search sequencer: hunt and bisection over the table through one shared
// adder and one shared compare, one table read per probe.
module chbl_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  chbl_pkg::chbl_cfg_t               cfg_i,
  input  logic                              in_valid_i,
  input  logic                              in_opcode_i,
  input  logic signed [chbl_pkg::VAL_W-1:0] in_key_i,
  output logic                              in_ready_o,
  output logic [chbl_pkg::IDX_W-1:0]        rd_addr_o,
  input  logic signed [chbl_pkg::VAL_W-1:0] rd_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output chbl_pkg::chbl_res_t               out_res_o
);

  localparam int IDX_W = chbl_pkg::IDX_W;
  localparam int LEN_W = chbl_pkg::LEN_W;
  localparam int STP_W = LEN_W + 1;
  localparam int SW    = LEN_W + 2;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_BIS  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // What the pending probe is for.
  localparam logic [1:0] M_FIRST  = 2'd0;
  localparam logic [1:0] M_UP     = 2'd1;
  localparam logic [1:0] M_DOWN   = 2'd2;
  localparam logic [1:0] M_BISECT = 2'd3;

  logic [2:0]                      state_q, state_d;
  logic [1:0]                      mode_q, mode_d;
  logic [IDX_W-1:0]                lo_q, lo_d, hi_q, hi_d, probe_q, probe_d;
  logic [LEN_W-1:0]                step_q, step_d;
  logic signed [chbl_pkg::VAL_W-1:0] key_q, key_d;
  logic [LEN_W-1:0]                n_q, n_d, rs_q, rs_d;
  logic                            err_q, err_d;
  logic [IDX_W-1:0]                prev_q, prev_d;
  logic                            lastc_q, lastc_d;
  logic                            out_valid_q, out_valid_d;
  chbl_pkg::chbl_res_t             out_res_q, out_res_d;

  // Shared adder.
  logic [IDX_W-1:0]      add_a;
  logic [STP_W-1:0]      add_b;
  logic                  add_sub;
  logic signed [SW-1:0]  sum_s;

  logic                  past;
  logic [LEN_W-1:0]      n_c;
  logic                  err_c;
  logic [LEN_W-1:0]      n_m1;
  logic                  sum_hits_top;
  logic                  sum_hits_bottom;
  logic [LEN_W-1:0]      span;
  logic [STP_W-1:0]      step2;

  // Final window.
  logic [IDX_W-1:0]      diff;
  logic                  corr;
  logic [IDX_W-1:0]      half;
  logic signed [SW-1:0]  start_s;
  logic [LEN_W-1:0]      lim;
  logic [IDX_W-1:0]      start;
  logic                  out_free;

  assign past  = chbl_pkg::at_or_past(key_q, rd_data_i, cfg_i.ascending);
  assign step2 = {step_q, 1'b0};

  // Operand selection for the shared adder.
  always_comb begin
    add_a   = lo_q;
    add_b   = STP_W'(1);
    add_sub = 1'b0;
    if (state_q == S_BIS) begin
      add_a = hi_q;
      add_b = STP_W'(lo_q);
    end else begin
      unique case (mode_q)
        M_FIRST: begin
          add_a   = lo_q;
          add_b   = STP_W'(1);
          add_sub = !past;
        end
        M_UP: begin
          add_a = hi_q;
          add_b = step2;
        end
        M_DOWN: begin
          add_a   = lo_q;
          add_b   = step2;
          add_sub = 1'b1;
        end
        M_BISECT: begin
          add_a = hi_q;
          add_b = STP_W'(lo_q);
        end
        default: ;
      endcase
    end
  end

  assign sum_s = add_sub
               ? $signed({{(SW-IDX_W){1'b0}}, add_a}) - $signed({1'b0, add_b})
               : $signed({{(SW-IDX_W){1'b0}}, add_a}) + $signed({1'b0, add_b});

  assign n_m1            = n_q - LEN_W'(1);
  assign sum_hits_top    = (sum_s >= $signed({2'b00, n_m1}));
  assign sum_hits_bottom = sum_s[SW-1] || (sum_s == '0);
  assign span            = {1'b0, hi_q} - {1'b0, lo_q};

  // Effective length and validity of a new search.
  always_comb begin
    n_c = (cfg_i.table_length > LEN_W'(chbl_pkg::TABLE_DEPTH))
        ? LEN_W'(chbl_pkg::TABLE_DEPTH) : cfg_i.table_length;
    err_c = (n_c < LEN_W'(2)) || (cfg_i.range_size < LEN_W'(2)) ||
            (cfg_i.range_size > n_c);
  end

  // Window start and correlation from the final lower index.
  always_comb begin
    diff    = (lo_q >= prev_q) ? (lo_q - prev_q) : (prev_q - lo_q);
    corr    = (diff <= cfg_i.corr_thresh);
    half    = IDX_W'((rs_q - LEN_W'(2)) >> 1);
    start_s = $signed({{(SW-IDX_W){1'b0}}, lo_q}) - $signed({{(SW-IDX_W){1'b0}}, half});
    lim     = n_q - rs_q;
    if (start_s > $signed({2'b00, lim})) begin
      start = lim[IDX_W-1:0];
    end else if (start_s[SW-1]) begin
      start = '0;
    end else begin
      start = start_s[IDX_W-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    probe_d     = probe_q;
    step_d      = step_q;
    key_d       = key_q;
    n_d         = n_q;
    rs_d        = rs_q;
    err_d       = err_q;
    prev_d      = prev_q;
    lastc_d     = lastc_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (in_opcode_i == chbl_pkg::OP_SEARCH)) begin
          n_d   = n_c;
          rs_d  = cfg_i.range_size;
          key_d = in_key_i;
          err_d = err_c;
          if (err_c) begin
            state_d = S_FIN;
          end else if (lastc_q && ({1'b0, prev_q} < n_c)) begin
            lo_d    = prev_q;
            probe_d = prev_q;
            mode_d  = M_FIRST;
            state_d = S_WAIT;
          end else begin
            lo_d    = '0;
            hi_d    = IDX_W'(n_c - LEN_W'(1));
            state_d = S_BIS;
          end
        end
      end
      S_WAIT: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (mode_q)
          M_FIRST: begin
            if (past) begin
              if (sum_hits_top) begin
                hi_d    = n_m1[IDX_W-1:0];
                state_d = S_BIS;
              end else begin
                hi_d    = sum_s[IDX_W-1:0];
                probe_d = sum_s[IDX_W-1:0];
                step_d  = LEN_W'(1);
                mode_d  = M_UP;
                state_d = S_WAIT;
              end
            end else begin
              hi_d = lo_q;
              if (sum_hits_bottom) begin
                lo_d    = '0;
                state_d = S_BIS;
              end else begin
                lo_d    = sum_s[IDX_W-1:0];
                probe_d = sum_s[IDX_W-1:0];
                step_d  = LEN_W'(1);
                mode_d  = M_DOWN;
                state_d = S_WAIT;
              end
            end
          end
          M_UP: begin
            if (!past) begin
              state_d = S_BIS;
            end else begin
              lo_d = hi_q;
              if (sum_hits_top) begin
                hi_d    = n_m1[IDX_W-1:0];
                state_d = S_BIS;
              end else begin
                hi_d    = sum_s[IDX_W-1:0];
                probe_d = sum_s[IDX_W-1:0];
                step_d  = step2[LEN_W-1:0];
                state_d = S_WAIT;
              end
            end
          end
          M_DOWN: begin
            if (past) begin
              state_d = S_BIS;
            end else begin
              hi_d = lo_q;
              if (sum_hits_bottom) begin
                lo_d    = '0;
                state_d = S_BIS;
              end else begin
                lo_d    = sum_s[IDX_W-1:0];
                probe_d = sum_s[IDX_W-1:0];
                step_d  = step2[LEN_W-1:0];
                state_d = S_WAIT;
              end
            end
          end
          M_BISECT: begin
            if (past) begin
              lo_d = probe_q;
            end else begin
              hi_d = probe_q;
            end
            state_d = S_BIS;
          end
          default: ;
        endcase
      end
      S_BIS: begin
        if (span > LEN_W'(1)) begin
          probe_d = sum_s[IDX_W:1];
          mode_d  = M_BISECT;
          state_d = S_WAIT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (err_q) begin
            out_res_d.range_start = '0;
            out_res_d.error       = 1'b1;
            out_res_d.correlated  = 1'b0;
          end else begin
            out_res_d.range_start = start;
            out_res_d.error       = 1'b0;
            out_res_d.correlated  = corr;
            prev_d                = lo_q;
            lastc_d               = corr;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      lastc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      lastc_q     <= lastc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    probe_q   <= probe_d;
    step_q    <= step_d;
    key_q     <= key_d;
    n_q       <= n_d;
    rs_q      <= rs_d;
    err_q     <= err_d;
    out_res_q <= out_res_d;
  end

  assign rd_addr_o   = probe_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

### hw/rtl/correlated_hunt_bisection_locator.sv
`timescale 1ns / 1ps

// Correlated hunt and bisection locator. A write beat stores one Q16.16
// value in the 1024-entry table; the block is ready again at once. A
// search beat makes the sequencer probe the table through its single
// read port. A hunt probe passes through a table read and then a
// compare, and a bisection probe through a midpoint, a table read and
// then a compare. A last bisection step ends the search, and then the
// result register is loaded. A full bisection of a 1024-entry table
// makes ten probes; the next beat can be taken in the first cycle in
// which the search's result is offered. A hunt from the previous index
// adds probes whose step doubles each time and narrows the bisection
// that follows. The input is not ready while a search is in progress.
// A finished result waits in the output register while the next beat
// is taken, and a search that finishes while that register is still
// full waits for it to drain. The table is not cleared by reset.
module correlated_hunt_bisection_locator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  chbl_in_if.sink                             in_if,
  chbl_out_if.source                          out_if,
  input  logic                                cfg_we_i,
  input  logic [chbl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [chbl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  chbl_pkg::chbl_cfg_t                cfg_q;
  chbl_pkg::chbl_wr_t                 wr;
  chbl_pkg::chbl_res_t                res;
  logic [chbl_pkg::IDX_W-1:0]         rd_addr;
  logic signed [chbl_pkg::VAL_W-1:0]  rd_data;
  logic                               in_ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_length <= chbl_pkg::RST_TABLE_LENGTH;
      cfg_q.range_size   <= chbl_pkg::RST_RANGE_SIZE;
      cfg_q.corr_thresh  <= chbl_pkg::RST_CORR_THRESH;
      cfg_q.ascending    <= chbl_pkg::RST_ASCENDING;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chbl_pkg::CFG_TABLE_LENGTH: cfg_q.table_length <= cfg_data_i[chbl_pkg::LEN_W-1:0];
        chbl_pkg::CFG_RANGE_SIZE:   cfg_q.range_size   <= cfg_data_i[chbl_pkg::LEN_W-1:0];
        chbl_pkg::CFG_CORR_THRESH:  cfg_q.corr_thresh  <= cfg_data_i[chbl_pkg::THR_W-1:0];
        chbl_pkg::CFG_ASCENDING:    cfg_q.ascending    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Table write on an accepted write beat.
  always_comb begin
    wr.en   = in_if.valid && in_ready && (in_if.opcode == chbl_pkg::OP_WRITE);
    wr.addr = in_if.entry_index;
    wr.data = in_if.entry_value;
  end

  chbl_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  chbl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_if.valid),
    .in_opcode_i (in_if.opcode),
    .in_key_i    (in_if.key),
    .in_ready_o  (in_ready),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_res_o   (res)
  );

  assign in_if.ready        = in_ready;
  assign out_if.range_start = res.range_start;
  assign out_if.error       = res.error;
  assign out_if.correlated  = res.correlated;

endmodule

### hw/rtl/chbl_checker.sv
`timescale 1ns / 1ps
`include "correlated_hunt_bisection_locator_macros.svh"

// Port-level checks for the locator.
module chbl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_opcode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [chbl_pkg::IDX_W-1:0] out_range_start_i,
  input logic                       out_error_i,
  input logic                       out_correlated_i
);

  // A stalled result beat stays offered.
  `CHBL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // An error result carries a zero window start and no correlation.
  `CHBL_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_i && out_error_i, (out_range_start_i == '0) && !out_correlated_i, "error result carries data")

  // A search keeps the input closed on the following cycle.
  `CHBL_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_opcode_i == chbl_pkg::OP_SEARCH), !in_ready_i, "input open during search")

  // A valid window of at least two entries never starts at the last index.
  `CHBL_ASSERT_NOW(a_start_range, clk_i, rst_ni, out_valid_i && !out_error_i, out_range_start_i != chbl_pkg::IDX_W'(chbl_pkg::TABLE_DEPTH - 1), "window start out of range")

endmodule

bind correlated_hunt_bisection_locator chbl_checker u_chbl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .in_opcode_i       (in_if.opcode),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .out_range_start_i (out_if.range_start),
  .out_error_i       (out_if.error),
  .out_correlated_i  (out_if.correlated)
);
